// File: src/dhcpo_pkg.sv
// ----------------------------------------------------------------------------
// dhcpo_pkg: shared types and constants of the DHCP option TLV parser
// Parse phases, outcome codes, register indexes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package dhcpo_pkg;

  localparam int CODE_COUNT = 256;
  localparam int CODE_W     = 8;
  localparam int OUT_LEN_W  = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [7:0] CODE_PAD = 8'h00;
  localparam logic [7:0] CODE_END = 8'hFF;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  typedef enum logic [1:0] {
    PH_CODE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    OUT_RUNNING = 2'd0,
    OUT_OK      = 2'd1,
    OUT_NO_LEN  = 2'd2,
    OUT_OVERRUN = 2'd3
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXT_0_63    = 2'd0,
    CFG_TEXT_64_127  = 2'd1,
    CFG_TEXT_128_191 = 2'd2,
    CFG_TEXT_192_255 = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                 has_data;
    logic [7:0]           out_byte;
    logic [7:0]           zeros_before;
    logic [OUT_LEN_W-1:0] value_offset;
    logic [CODE_W-1:0]    option_code;
    logic                 option_end;
    logic [OUT_LEN_W-1:0] total_length;
    outcome_t             outcome;
    logic                 parse_done;
  } res_t;

endpackage

`default_nettype wire

// File: src/dhcpo_ram.sv
// ----------------------------------------------------------------------------
// dhcpo_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcpo_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/dhcpo_cfg.sv
// ----------------------------------------------------------------------------
// dhcpo_cfg: text-code mask registers
// Four 64-bit words written over the config channel; one bit looked up per code.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcpo_cfg import dhcpo_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  input  wire logic [CODE_W-1:0]     code,
  output logic                       is_text
);

  logic [CFG_DATA_W-1:0] text_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        text_r[i] <= '0;
      end
    end else if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        CFG_TEXT_0_63:    text_r[0] <= wr_data;
        CFG_TEXT_64_127:  text_r[1] <= wr_data;
        CFG_TEXT_128_191: text_r[2] <= wr_data;
        CFG_TEXT_192_255: text_r[3] <= wr_data;
        default: ;
      endcase
    end
  end

  assign is_text = text_r[code[7:6]][code[5:0]];

endmodule

`default_nettype wire

// File: src/dhcpo_core.sv
// ----------------------------------------------------------------------------
// dhcpo_core: option parse state machine
// Walks code, length and value bytes; keeps per-code lengths in the RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcpo_core import dhcpo_pkg::*; #(
  parameter int MAX_BUFFER_BYTES = 512,
  parameter int MAX_VALUE_BYTES  = 2048,
  localparam int LEN_W = $clog2(MAX_VALUE_BYTES)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_acc,
  input  wire logic [7:0]        in_byte,
  input  wire logic              buffer_start,
  input  wire logic [9:0]        buffer_length,
  input  wire logic              new_packet,
  input  wire logic              text_bit,
  output logic [CODE_W-1:0]      lookup_code,
  output logic                   ram_we,
  output logic [CODE_W-1:0]      ram_waddr,
  output logic [LEN_W-1:0]       ram_wdata,
  output logic                   ram_re,
  output logic [CODE_W-1:0]      ram_raddr,
  input  wire logic [LEN_W-1:0]  ram_rdata,
  output logic                   res_valid,
  output res_t                   res
);

  localparam int POS_W   = $clog2(MAX_BUFFER_BYTES + 1);
  localparam int CMP_W   = (POS_W > 10) ? POS_W : 10;
  localparam int SUM_W   = ((POS_W > 8) ? POS_W : 8) + 1;
  localparam int LEN_CAP = MAX_VALUE_BYTES - 1;

  phase_t                phase_r, phase_nxt, phase_e;
  logic [POS_W-1:0]      pos_r, pos_nxt, pos_e;
  logic [POS_W-1:0]      end_r, end_nxt, end_e;
  logic [CODE_W-1:0]     cur_r, cur_nxt;
  logic [7:0]            left_r, left_nxt, left_e;
  logic [7:0]            pz_r, pz_nxt, pz_e;
  logic                  txt_r, txt_nxt, txt_e;
  logic [LEN_W-1:0]      rl_r, rl_nxt, rl_e;
  logic [CODE_COUNT-1:0] seen_r, seen_nxt, seen_e;

  logic [CMP_W-1:0]      blen_c;
  logic                  have;
  logic                  ended;
  logic                  last_in_buf;
  logic                  last_val;
  logic [LEN_W-1:0]      off;
  logic [LEN_W-1:0]      rl_new;

  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [7:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {{(LEN_W - 7){1'b0}}, b};
    return (s > (LEN_W + 1)'(LEN_CAP)) ? LEN_W'(LEN_CAP) : s[LEN_W-1:0];
  endfunction

  assign lookup_code = cur_r;
  // The code byte's read lands in time for the length byte that follows it.
  assign ram_re      = in_acc;
  assign ram_raddr   = in_byte;
  assign res_valid   = in_acc && have;

  always_comb begin
    phase_e = phase_r;
    pos_e   = pos_r;
    end_e   = end_r;
    left_e  = left_r;
    pz_e    = pz_r;
    txt_e   = txt_r;
    rl_e    = rl_r;
    seen_e  = seen_r;
    blen_c  = CMP_W'(buffer_length);

    if (buffer_start) begin
      phase_e = PH_CODE;
      pos_e   = '0;
      end_e   = (blen_c > CMP_W'(MAX_BUFFER_BYTES)) ? POS_W'(MAX_BUFFER_BYTES)
                                                    : POS_W'(blen_c);
      left_e  = '0;
      pz_e    = '0;
      txt_e   = 1'b0;
      rl_e    = '0;
      if (new_packet) begin
        seen_e = '0;
      end
    end

    phase_nxt = phase_e;
    pos_nxt   = pos_e;
    end_nxt   = end_e;
    cur_nxt   = cur_r;
    left_nxt  = left_e;
    pz_nxt    = pz_e;
    txt_nxt   = txt_e;
    rl_nxt    = rl_e;
    seen_nxt  = seen_e;

    res       = '0;
    have      = 1'b0;
    ended     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cur_r;
    ram_wdata = rl_e;
    off       = sat_add(rl_e, pz_e);
    rl_new    = rl_e;
    last_val  = (left_e <= 8'd1);
    last_in_buf = ({1'b0, pos_e} + (POS_W + 1)'(1)) >= {1'b0, end_e};

    if (phase_e == PH_DONE || pos_e >= end_e) begin
      if (buffer_start) begin
        res.outcome    = OUT_OK;
        res.parse_done = 1'b1;
        phase_nxt      = PH_DONE;
        have           = 1'b1;
      end
    end else begin
      case (phase_e)
        PH_CODE: begin
          if (in_byte == CODE_PAD) begin
            ended = 1'b1;
          end else if (in_byte == CODE_END) begin
            res.outcome    = OUT_OK;
            res.parse_done = 1'b1;
            phase_nxt      = PH_DONE;
            have           = 1'b1;
          end else if (last_in_buf) begin
            res.option_code = in_byte;
            res.outcome     = OUT_NO_LEN;
            res.parse_done  = 1'b1;
            phase_nxt       = PH_DONE;
            have            = 1'b1;
          end else begin
            cur_nxt   = in_byte;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          if (SUM_W'(pos_e) + SUM_W'(in_byte) >= SUM_W'(end_e)) begin
            res.option_code = cur_r;
            res.outcome     = OUT_OVERRUN;
            res.parse_done  = 1'b1;
            phase_nxt       = PH_DONE;
            have            = 1'b1;
          end else begin
            rl_new   = seen_e[cur_r] ? ram_rdata : '0;
            rl_nxt   = rl_new;
            pz_nxt   = '0;
            txt_nxt  = text_bit;
            left_nxt = in_byte;
            if (in_byte == 8'd0) begin
              // empty option: record it with its unchanged length
              seen_nxt[cur_r]  = 1'b1;
              ram_we           = 1'b1;
              ram_wdata        = rl_new;
              res.option_code  = cur_r;
              res.option_end   = 1'b1;
              res.total_length = OUT_LEN_W'(rl_new);
              phase_nxt        = PH_CODE;
              have             = 1'b1;
              ended            = 1'b1;
            end else begin
              phase_nxt = PH_VALUE;
            end
          end
        end
        default: begin
          if (txt_e && in_byte == CHAR_NUL) begin
            // hold back the NUL; count it unless it trails the value
            if (!last_val && pz_e < 8'd255) begin
              pz_nxt = pz_e + 8'd1;
            end
          end else begin
            res.has_data     = 1'b1;
            res.out_byte     = in_byte;
            res.zeros_before = pz_e;
            res.value_offset = OUT_LEN_W'(off);
            res.option_code  = cur_r;
            rl_new           = sat_add(off, 8'd1);
            rl_nxt           = rl_new;
            pz_nxt           = '0;
            have             = 1'b1;
          end
          if (left_e != 8'd0) begin
            left_nxt = left_e - 8'd1;
          end
          if (last_val) begin
            pz_nxt           = '0;
            seen_nxt[cur_r]  = 1'b1;
            ram_we           = 1'b1;
            ram_wdata        = rl_new;
            res.option_code  = cur_r;
            res.option_end   = 1'b1;
            res.total_length = OUT_LEN_W'(rl_new);
            phase_nxt        = PH_CODE;
            have             = 1'b1;
            ended            = 1'b1;
          end
        end
      endcase

      if (ended && last_in_buf) begin
        res.outcome    = OUT_OK;
        res.parse_done = 1'b1;
        phase_nxt      = PH_DONE;
        have           = 1'b1;
      end
      pos_nxt = pos_e + POS_W'(1);
    end

    if (!in_acc) begin
      ram_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CODE;
      pos_r   <= '0;
      end_r   <= '0;
      cur_r   <= '0;
      left_r  <= '0;
      pz_r    <= '0;
      txt_r   <= 1'b0;
      rl_r    <= '0;
      seen_r  <= '0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      end_r   <= end_nxt;
      cur_r   <= cur_nxt;
      left_r  <= left_nxt;
      pz_r    <= pz_nxt;
      txt_r   <= txt_nxt;
      rl_r    <= rl_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/dhcp_option_tlv_parser_top.sv
// ----------------------------------------------------------------------------
// dhcp_option_tlv_parser_top: DHCP option area TLV parser
// Parses option bytes, tags value bytes with code and offset, reports outcome.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  --------+-----------+-------------------------------------------------------
//  in_     | sink      | tdata: in_byte, buffer_length; tuser: start, new pkt
//  out_    | source    | tdata: value fields; tuser: has_data; tlast: done
//  cfg_    | sink      | index + 64-bit text-code mask word
//
//  One item per cycle sustained while in_tready is high; a result appears in the cycle after its item.
//  Rate is set by the per-code length RAM: read on the code byte, used on the
//  length byte, written when the option ends.
//  Reset clears parse state and seen-code flags; length RAM needs no clearing.
//  in_tready drops only while a result waits and out_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcp_option_tlv_parser_top import dhcpo_pkg::*; #(
  parameter int MAX_BUFFER_BYTES = 512,
  parameter int MAX_VALUE_BYTES  = 2048
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [23:0]           in_tdata,   // in_byte, buffer_length, pad
  input  wire logic [1:0]            in_tuser,   // buffer_start, new_packet
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [55:0]                out_tdata,  // out_byte, zeros_before,
                                                 // value_offset, option_code,
                                                 // option_end, total_length,
                                                 // outcome, pad
  output logic                       out_tuser,  // has_data
  output logic                       out_tlast,  // parse_done
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LEN_W = $clog2(MAX_VALUE_BYTES);

  logic              in_acc;
  logic              text_bit;
  logic [CODE_W-1:0] lookup_code;
  logic              ram_we;
  logic [CODE_W-1:0] ram_waddr;
  logic [LEN_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [CODE_W-1:0] ram_raddr;
  logic [LEN_W-1:0]  ram_rdata;
  logic              res_valid;
  res_t              res;
  logic              out_valid_r;
  res_t              out_res_r;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  dhcpo_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .code     (lookup_code),
    .is_text  (text_bit)
  );

  dhcpo_ram #(
    .WIDTH (LEN_W),
    .DEPTH (CODE_COUNT)
  ) u_len_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dhcpo_core #(
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES),
    .MAX_VALUE_BYTES  (MAX_VALUE_BYTES)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_acc        (in_acc),
    .in_byte       (in_tdata[7:0]),
    .buffer_start  (in_tuser[0]),
    .buffer_length (in_tdata[17:8]),
    .new_packet    (in_tuser[1]),
    .text_bit      (text_bit),
    .lookup_code   (lookup_code),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .res_valid     (res_valid),
    .res           (res)
  );

  // Output register: load a new result whenever the slot frees up.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.has_data;
  assign out_tlast  = out_res_r.parse_done;
  assign out_tdata  = {7'd0,
                       out_res_r.outcome,
                       out_res_r.total_length,
                       out_res_r.option_end,
                       out_res_r.option_code,
                       out_res_r.value_offset,
                       out_res_r.zeros_before,
                       out_res_r.out_byte};

endmodule

`default_nettype wire

// File: src/dhcpo_chk.sv
// ----------------------------------------------------------------------------
// dhcpo_chk: port-level checks for the DHCP option TLV parser
// Watches the result stream for ordering and field consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcpo_chk import dhcpo_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // every new result follows an accepted item
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result without an accepted item");

  // parse end and outcome agree
  a_done_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[48:47] != OUT_RUNNING)))
    else $error("parse_done and outcome disagree");

  // a value byte never comes with an error outcome
  a_data_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[48:47] != OUT_NO_LEN && out_tdata[48:47] != OUT_OVERRUN)
    else $error("value byte with error outcome");

  // total length only on option end
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[35] |-> out_tdata[46:36] == '0)
    else $error("total_length without option_end");

endmodule

bind dhcp_option_tlv_parser_top dhcpo_chk u_chk (.*);

`default_nettype wire
